[rtl/assert_macros.svh]
// Assertion macros for the liveness table RTL; included by dlt_ctrl only.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DLT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DLT_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DLT_ASSERT(name, clk, rst_n, prop, msg)
`define DLT_ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif
`endif

[rtl/dlt_pkg.sv]
// Types and codes of the device liveness table.
// Used by dlt_mem, dlt_ctrl and device_liveness_table; depends on nothing.
package dlt_pkg;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_REFRESH = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_LIST    = 3'd4;

  localparam logic [2:0] ST_REFRESHED = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_ENTRY     = 3'd5;
  localparam logic [2:0] ST_END       = 3'd6;

  localparam logic [15:0] AGE_LIMIT_RST = 16'd60;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] ip_address;
    logic [7:0]  sensor_code;
    logic [31:0] now;
  } dlt_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_ip;
    logic [7:0]  out_sensor;
    logic [4:0]  entry_count;
    logic        last_result;
  } dlt_result_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [7:0]  sensor;
    logic [31:0] seen;
  } dlt_entry_t;

endpackage

[rtl/dlt_mem.sv]
// Entry store of the liveness table: one write port, one registered read port.
// Depends on dlt_pkg for the entry type.
module dlt_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output dlt_pkg::dlt_entry_t        rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  dlt_pkg::dlt_entry_t        wr_data_i
);

  dlt_pkg::dlt_entry_t mem_q [DEPTH];
  dlt_pkg::dlt_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/dlt_ctrl.sv]
// Command sequencer of the liveness table: scans, rewrites and compacts the
// entry store one entry per cycle. Depends on dlt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlt_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  dlt_pkg::dlt_item_t         item_i,
  output logic                       busy_o,
  input  logic [15:0]                age_limit_i,
  output logic                       result_valid_o,
  output dlt_pkg::dlt_result_t       result_o,
  output logic                       rd_en_o,
  output logic [$clog2(DEPTH)-1:0]   rd_addr_o,
  input  dlt_pkg::dlt_entry_t        rd_data_i,
  output logic                       wr_en_o,
  output logic [$clog2(DEPTH)-1:0]   wr_addr_o,
  output dlt_pkg::dlt_entry_t        wr_data_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_AGE   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]           state_q, state_d;
  dlt_pkg::dlt_item_t   item_q, item_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic                 pend_q, pend_d;
  logic [IW-1:0]        pend_idx_q, pend_idx_d;
  logic                 res_valid_q, res_valid_d;
  dlt_pkg::dlt_result_t res_q, res_d;

  logic                 more_rd;
  logic                 rd_en;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  dlt_pkg::dlt_entry_t  wr_data;
  logic [31:0]          age;
  logic                 keep;
  logic [31:0]          cnt_wide;

  assign more_rd = scan_q < count_q;
  assign age     = item_q.now - rd_data_i.seen;
  assign keep    = age <= {16'd0, age_limit_i};

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    scan_d      = scan_q;
    wr_d        = wr_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = pend_idx_q;
    wr_data     = rd_data_i;
    cnt_wide    = '0;

    // Every working state streams reads through the table in order; the data
    // comes back in the next cycle, tagged by pend_q and pend_idx_q.
    if (state_q != S_IDLE && more_rd) begin
      rd_en      = 1'b1;
      scan_d     = scan_q + CW'(1);
      pend_d     = 1'b1;
      pend_idx_d = scan_q[IW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          scan_d = '0;
          wr_d   = '0;
          case (item_i.cmd)
            dlt_pkg::CMD_APPEND: begin
              res_valid_d = 1'b1;
              res_d       = '0;
              res_d.status      = dlt_pkg::ST_FULL;
              res_d.last_result = 1'b1;
              if (count_q != DepthC) begin
                wr_en        = 1'b1;
                wr_addr      = count_q[IW-1:0];
                wr_data.ip     = item_i.ip_address;
                wr_data.sensor = item_i.sensor_code;
                wr_data.seen   = item_i.now;
                count_d      = count_q + CW'(1);
                res_d.status = dlt_pkg::ST_ADDED;
              end
            end
            dlt_pkg::CMD_ADD, dlt_pkg::CMD_REFRESH, dlt_pkg::CMD_DELETE: begin
              state_d = S_SCAN;
            end
            dlt_pkg::CMD_LIST: begin
              state_d = S_AGE;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (pend_q && rd_data_i.ip == item_q.ip_address) begin
          pend_d = 1'b0;
          if (item_q.cmd == dlt_pkg::CMD_DELETE) begin
            // Later entries move down by one, starting right after the match.
            state_d = S_SHIFT;
            scan_d  = CW'(pend_idx_q) + CW'(1);
          end else begin
            state_d      = S_IDLE;
            wr_en        = 1'b1;
            wr_addr      = pend_idx_q;
            wr_data.seen = item_q.now;
            res_valid_d  = 1'b1;
            res_d        = '0;
            res_d.status      = dlt_pkg::ST_REFRESHED;
            res_d.last_result = 1'b1;
          end
        end else if (!pend_q && !more_rd) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          res_d       = '0;
          res_d.status      = dlt_pkg::ST_NOT_FOUND;
          res_d.last_result = 1'b1;
          if (item_q.cmd == dlt_pkg::CMD_ADD) begin
            res_d.status = dlt_pkg::ST_FULL;
            if (count_q != DepthC) begin
              wr_en          = 1'b1;
              wr_addr        = count_q[IW-1:0];
              wr_data.ip     = item_q.ip_address;
              wr_data.sensor = item_q.sensor_code;
              wr_data.seen   = item_q.now;
              count_d        = count_q + CW'(1);
              res_d.status   = dlt_pkg::ST_ADDED;
            end
          end
        end
      end

      S_SHIFT: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_q - IW'(1);
        end else if (!more_rd) begin
          state_d     = S_IDLE;
          count_d     = count_q - CW'(1);
          res_valid_d = 1'b1;
          res_d       = '0;
          res_d.status      = dlt_pkg::ST_DELETED;
          res_d.last_result = 1'b1;
        end
      end

      S_AGE: begin
        if (pend_q) begin
          if (keep) begin
            wr_en   = 1'b1;
            wr_addr = wr_q[IW-1:0];
            wr_d    = wr_q + CW'(1);
          end
        end else if (!more_rd) begin
          state_d = S_EMIT;
          count_d = wr_q;
          scan_d  = '0;
        end
      end

      S_EMIT: begin
        if (pend_q) begin
          res_valid_d       = 1'b1;
          res_d             = '0;
          res_d.status      = dlt_pkg::ST_ENTRY;
          res_d.out_ip      = rd_data_i.ip;
          res_d.out_sensor  = rd_data_i.sensor;
        end else if (!more_rd) begin
          state_d           = S_IDLE;
          res_valid_d       = 1'b1;
          res_d             = '0;
          res_d.status      = dlt_pkg::ST_END;
          res_d.last_result = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    cnt_wide          = 32'(count_d);
    res_d.entry_count = cnt_wide[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      wr_q        <= wr_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;
  assign rd_en_o        = rd_en;
  assign rd_addr_o      = scan_q[IW-1:0];
  assign wr_en_o        = wr_en;
  assign wr_addr_o      = wr_addr;
  assign wr_data_o      = wr_data;

  `DLT_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > DepthC, "entry count above depth")
  `DLT_ASSERT(a_last_idle, clk_i, rst_ni, res_valid_q && res_q.last_result |-> state_q == S_IDLE, "final item result while still busy")
  `DLT_ASSERT(a_wr_in_table, clk_i, rst_ni, wr_en |-> CW'(wr_addr) <= count_q, "write beyond the live entries")
  `DLT_ASSERT(a_entry_from_emit, clk_i, rst_ni, res_valid_q && res_q.status == dlt_pkg::ST_ENTRY |-> $past(state_q) == S_EMIT, "list entry outside the listing pass")

endmodule

[rtl/device_liveness_table.sv]
// Device liveness table: insertion-ordered table of device entries with
// ageing. Depends on dlt_pkg, dlt_ctrl and dlt_mem.
//
// Usage: present a command item on item_i with start_i high while busy_o is
// low; the item is taken at that clock edge. Results appear on result_o for
// one cycle each, flagged by result_valid_o; the last result of an item has
// last_result set. The receiver cannot hold results back, so every result
// is simply taken in the cycle it is shown.
// Command flow:
//   append: one result the cycle after start, ready again at once.
//   add-or-refresh and refresh: a search that stops at the first match.
//   delete: search, then shift the later entries down, one entry a cycle;
//   a miss ends with a not-found result.
//   list: ageing pass, then one result a cycle per kept entry, then end.
// The entry store has a single read and a single write port and is walked one
// entry per cycle. Unused command codes are taken and give no result. The user
// writes the age limit through cfg_we_i/cfg_wdata_i while the block is idle;
// the block itself does not enforce this.
// Reset empties the table and sets the age limit to 60; no clearing pass runs.
module device_liveness_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  dlt_pkg::dlt_item_t   item_i,
  output logic                 busy_o,
  output logic                 result_valid_o,
  output dlt_pkg::dlt_result_t result_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic [15:0]         age_limit_q;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  dlt_pkg::dlt_entry_t rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  dlt_pkg::dlt_entry_t wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_limit_q <= dlt_pkg::AGE_LIMIT_RST;
    end else if (cfg_we_i) begin
      age_limit_q <= cfg_wdata_i;
    end
  end

  dlt_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .age_limit_i    (age_limit_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  dlt_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule
